/* hdl/pbue_pkg.sv */
package pbue_pkg;

  // pulse duration and result width
  localparam int DUR_W = 16;

  // default store depth
  localparam int MAX_PULSES_DEF = 256;

  // tolerance is min * 25 / 100, which is exactly floor(min / 4)
  localparam int TOL_SHIFT = 2;

endpackage

/* hdl/pbue_div.sv */
module pbue_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  output logic                       done,
  output logic [pbue_pkg::DUR_W-1:0] quot
);
  import pbue_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  q;
  logic [DEN_W-1:0]  den_r;

  logic [DEN_W:0]    trial;
  logic              fits;

  // one restoring step: shift in the next numerator bit and try a subtract
  assign trial = {rem, q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        rem     <= '0;
        q       <= num;
        den_r   <= den;
      end else if (running) begin
        rem  <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        q    <= {q[NUM_W-2:0], fits};
        step <= step + 1'b1;
        if (step == STEP_W'(NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // the mean never exceeds the largest pulse, so the low bits hold it all
  assign quot = q[DUR_W-1:0];

endmodule

/* hdl/pulse_base_unit_estimator.sv */
// channel   | ports                   | handshake
// ----------+-------------------------+----------------------------------
// pulse in  | duration, last          | word taken when start & !busy
// result    | base_unit               | done high for one cycle, no stall
//
// a word is stored in the cycle it is taken, while the store has room; after
// the last one the scan reads every stored word, then the divider takes a
// load step, 16 + count width steps and a finish step; done follows and busy
// drops with it. if no pulse qualifies, the divider is skipped. reset clears
// count, minimum and control, not the store.
// the receiver cannot stall: base_unit is valid only while done is high.
module pulse_base_unit_estimator #(
  parameter int MAX_PULSES = pbue_pkg::MAX_PULSES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [pbue_pkg::DUR_W-1:0] duration,
  input  logic                       last,
  output logic                       done,
  output logic [pbue_pkg::DUR_W-1:0] base_unit
);
  import pbue_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PULSES);
  localparam int CNT_W  = $clog2(MAX_PULSES + 1);
  localparam int SUM_W  = DUR_W + CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV
  } state_t;

  state_t state;

  logic [DUR_W-1:0] mem [MAX_PULSES];
  logic [DUR_W-1:0] rd_data;
  logic             rd_en;
  logic             rd_vld;
  logic             wr_en;

  logic [CNT_W-1:0] pulse_count;
  logic [DUR_W-1:0] running_min;
  logic [CNT_W-1:0] scan_idx;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] hits;

  logic             accept;
  logic             room;
  logic [DUR_W-1:0] tol;
  logic [DUR_W-1:0] delta;
  logic             near;

  logic             div_start;
  logic             div_done;
  logic [DUR_W-1:0] div_quot;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;
  assign room   = pulse_count < CNT_W'(MAX_PULSES);
  assign wr_en  = accept && room;
  assign rd_en  = state == ST_SCAN && scan_idx != pulse_count;

  // pulse store: written while loading, read during the scan, never both
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pulse_count[ADDR_W-1:0]] <= duration;
    end
    if (rd_en) begin
      rd_data <= mem[scan_idx[ADDR_W-1:0]];
    end
  end

  // distance of the word just read from the minimum
  assign tol   = running_min >> TOL_SHIFT;
  assign delta = (rd_data >= running_min) ? rd_data - running_min : running_min - rd_data;
  assign near  = delta < tol;

  // sequencer: load, scan, divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pulse_count <= '0;
      running_min <= '0;
      rd_vld      <= 1'b0;
      div_start   <= 1'b0;
      done        <= 1'b0;
      scan_idx    <= '0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      rd_vld    <= rd_en;
      unique case (state)
        ST_IDLE: begin
          if (wr_en) begin
            pulse_count <= pulse_count + 1'b1;
            if (running_min == '0 || duration < running_min) begin
              running_min <= duration;
            end
          end
          if (accept && last) begin
            state    <= ST_SCAN;
            scan_idx <= '0;
            sum      <= '0;
            hits     <= '0;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (rd_vld && near) begin
            sum  <= sum + SUM_W'(rd_data);
            hits <= hits + 1'b1;
          end
          // all reads issued and the last word accumulated
          if (!rd_en && !rd_vld) begin
            if (hits == '0) begin
              base_unit   <= '0;
              done        <= 1'b1;
              state       <= ST_IDLE;
              pulse_count <= '0;
              running_min <= '0;
            end else begin
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            base_unit   <= div_quot;
            done        <= 1'b1;
            state       <= ST_IDLE;
            pulse_count <= '0;
            running_min <= '0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // mean of the pulses near the minimum
  pbue_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum),
    .den   (hits),
    .done  (div_done),
    .quot  (div_quot)
  );

  // a result only ever follows a train being worked on
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != ST_IDLE)
    else $error("result without a finished train");

  // read data in flight only while scanning
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == ST_SCAN)
    else $error("store read outside the scan");

  // the fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pulse_count <= CNT_W'(MAX_PULSES))
    else $error("pulse count beyond store depth");

  // hits cannot outrun the words read
  a_hits_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> hits <= scan_idx)
    else $error("more hits than words scanned");

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pbue_pkg::*;

  localparam int DEPTH      = MAX_PULSES_DEF;
  localparam int TAIL_WAIT  = 600;
  localparam int WORD_COUNT = 2000;

  // one queued pulse word with its pacing
  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic             fin;
    logic             hold;
    logic [7:0]       gap;
  } pulse_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [DUR_W-1:0] duration = '0;
  logic             last = 1'b0;
  logic             done;
  logic [DUR_W-1:0] base_unit;

  pulse_word_t      pulse_words[$];
  logic [DUR_W-1:0] base_unit_due[$];

  // predictor state
  logic [DUR_W-1:0] pulse_mem[DEPTH];
  int unsigned      stored_cnt = 0;
  logic [DUR_W-1:0] shortest = '0;

  int               errors = 0;
  int               word_total = 0;
  int               idle_cnt = 0;
  pulse_word_t      head;
  logic [DUR_W-1:0] want;

  pulse_base_unit_estimator #(
    .MAX_PULSES(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .duration (duration),
    .last     (last),
    .done     (done),
    .base_unit(base_unit)
  );

  always #2 clk = ~clk;

  // store one accepted word, close the train and predict on the last one
  task automatic take_pulse_word(input logic [DUR_W-1:0] d, input logic fin);
    int unsigned tol;
    int unsigned delta;
    int unsigned sum;
    int unsigned hits;
    int unsigned k;
    int unsigned mean;
    if (stored_cnt < DEPTH) begin
      pulse_mem[stored_cnt] = d;
      stored_cnt++;
      if (shortest == '0 || d < shortest) shortest = d;
    end
    if (fin) begin
      tol  = (int'(shortest) * 25) / 100;
      sum  = 0;
      hits = 0;
      for (k = 0; k < stored_cnt; k++) begin
        delta = (pulse_mem[k] >= shortest) ? pulse_mem[k] - shortest
                                           : shortest - pulse_mem[k];
        if (delta < tol) begin
          sum += pulse_mem[k];
          hits++;
        end
      end
      mean = (hits == 0) ? 0 : sum / hits;
      base_unit_due.push_back(mean[DUR_W-1:0]);
      stored_cnt = 0;
      shortest   = '0;
    end
  endtask

  // idle length before a word: mostly none, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  task automatic push_word(input int d, input bit fin, input int gap, input bit hold);
    pulse_word_t w;
    w.dur  = d[DUR_W-1:0];
    w.fin  = fin;
    w.hold = hold;
    w.gap  = gap[7:0];
    pulse_words.push_back(w);
    word_total++;
  endtask

  // random train, mostly clustered around a base, with zeros and extremes mixed in
  task automatic queue_train(input int len, input bit calm);
    int mode;
    int base;
    int spread;
    int v;
    int r;
    int k;
    mode   = $urandom_range(9);
    base   = (mode == 1) ? $urandom_range(1, 20) : $urandom_range(65535);
    spread = base / 3 + 1;
    for (k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (mode == 0 || r < 3) v = $urandom_range(65535);
      else if (r < 7) v = 0;
      else if (r < 9) v = 65535;
      else v = base - spread + int'($urandom_range(2 * spread));
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      push_word(v, k == len - 1, calm ? 0 : pick_gap(),
                k == 0 && $urandom_range(49) == 0);
    end
  endtask

  // driver: present queued words, update the predictor on each accepted word
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_cnt = 0;
    end else begin
      if (start && !busy) take_pulse_word(duration, last);
      if (!start || !busy) begin
        if (pulse_words.size() != 0) begin
          head = pulse_words[0];
          if (idle_cnt < head.gap) begin
            idle_cnt++;
            start <= 1'b0;
          end else if (head.hold && base_unit_due.size() != 0) begin
            start <= 1'b0;
          end else begin
            head = pulse_words.pop_front();
            duration <= head.dur;
            last     <= head.fin;
            start    <= 1'b1;
            idle_cnt = 0;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done strobe must match the oldest predicted base unit
  always @(posedge clk) begin
    if (!rst && done) begin
      if (base_unit_due.size() == 0) begin
        $display("%0t: unexpected base_unit expected none actual %0d", $time, base_unit);
        errors++;
      end else begin
        want = base_unit_due.pop_front();
        if (base_unit !== want) begin
          $display("%0t: base_unit mismatch expected %0d actual %0d",
                   $time, want, base_unit);
          errors++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int train_idx;
    int r;
    int len;
    bit calm;

    // directed trains
    push_word(0, 1, pick_gap(), 0);                  // single zero
    push_word(65535, 1, pick_gap(), 0);              // single maximum
    push_word(1, 1, pick_gap(), 0);                  // zero tolerance
    push_word(4, 1, pick_gap(), 0);                  // smallest nonzero tolerance
    push_word(0, 0, pick_gap(), 1);                  // leading zero, drain first
    push_word(100, 0, pick_gap(), 0);
    push_word(104, 0, pick_gap(), 0);
    push_word(200, 1, pick_gap(), 0);
    push_word(8, 0, pick_gap(), 0);                  // zero clears the minimum
    push_word(0, 0, pick_gap(), 0);
    push_word(12, 1, pick_gap(), 0);
    push_word(0, 0, pick_gap(), 0);                  // all zero
    push_word(0, 0, pick_gap(), 0);
    push_word(0, 1, pick_gap(), 0);
    push_word(60000, 0, pick_gap(), 0);              // large values near the top
    push_word(65535, 0, pick_gap(), 0);
    push_word(65535, 0, pick_gap(), 0);
    push_word(52000, 1, pick_gap(), 0);
    push_word(40000, 0, pick_gap(), 0);              // distance equal to tolerance
    push_word(50000, 1, pick_gap(), 0);

    // random trains, a few of them filling or overrunning the store
    train_idx = 0;
    calm      = 0;
    while (word_total < WORD_COUNT) begin
      if ($urandom_range(9) == 0) calm = !calm;
      r = $urandom_range(99);
      if (train_idx == 10) len = DEPTH;
      else if (train_idx == 40) len = DEPTH + 1;
      else if (train_idx == 70) len = DEPTH + 14;
      else if (r < 60) len = $urandom_range(1, 6);
      else if (r < 90) len = $urandom_range(7, 24);
      else len = $urandom_range(25, 60);
      queue_train(len, calm);
      train_idx++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pulse_words.size() != 0 || start || base_unit_due.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
